@@ hw/rtl/mcaq_pkg.sv @@
// ----------------------------------------------------------------------------
// mcaq_pkg
// Shared types and constants for the motion confirmation alarm qualifier.
// ----------------------------------------------------------------------------
package mcaq_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 32;

    // stream payload widths, padded to whole bytes
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STARTUP_TIME   = 3'd0,
        CFG_GRACE          = 3'd1,
        CFG_MIN_MOTION     = 3'd2,
        CFG_DEBOUNCE       = 3'd3,
        CFG_CONFIRM_WINDOW = 3'd4,
        CFG_CONFIRM_COUNT  = 3'd5,
        CFG_ALARM_DURATION = 3'd6
    } t_cfg_idx;

    localparam logic [TIME_W-1:0]  RST_STARTUP_TIME   = 32'd0;
    localparam logic [TIME_W-1:0]  RST_GRACE          = 32'd30000;
    localparam logic [TIME_W-1:0]  RST_MIN_MOTION     = 32'd500;
    localparam logic [TIME_W-1:0]  RST_DEBOUNCE       = 32'd2000;
    localparam logic [TIME_W-1:0]  RST_CONFIRM_WINDOW = 32'd10000;
    localparam logic [COUNT_W-1:0] RST_CONFIRM_COUNT  = 8'd2;
    localparam logic [TIME_W-1:0]  RST_ALARM_DURATION = 32'd30000;

    typedef struct packed {
        logic [TIME_W-1:0]  startup_time_ms;
        logic [TIME_W-1:0]  grace_ms;
        logic [TIME_W-1:0]  min_motion_ms;
        logic [TIME_W-1:0]  debounce_ms;
        logic [TIME_W-1:0]  confirm_window_ms;
        logic [COUNT_W-1:0] confirm_count;
        logic [TIME_W-1:0]  alarm_duration_ms;
    } t_cfg;

    typedef struct packed {
        logic               alarm_active;
        logic [TIME_W-1:0]  alarm_begin;
        logic [TIME_W-1:0]  last_event_time;
        logic               event_latched;
        logic [COUNT_W-1:0] event_tally;
        logic [TIME_W-1:0]  window_begin;
        logic [TIME_W-1:0]  high_begin;
        logic               high_run;
    } t_state;

    typedef struct packed {
        logic [COUNT_W-1:0] events_seen;
        logic               alarm_expired;
        logic               alarm_started;
        logic               alarm_on;
    } t_result;

endpackage

@@ hw/rtl/mcaq_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mcaq_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mcaq_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mcaq_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [mcaq_pkg::CFG_W-1:0]          i_cfg_wdata,
    output mcaq_pkg::t_cfg                      o_cfg
);

    mcaq_pkg::t_cfg r_cfg;
    mcaq_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (mcaq_pkg::t_cfg_idx'(i_cfg_addr))
                mcaq_pkg::CFG_STARTUP_TIME:   n_cfg.startup_time_ms   = i_cfg_wdata;
                mcaq_pkg::CFG_GRACE:          n_cfg.grace_ms          = i_cfg_wdata;
                mcaq_pkg::CFG_MIN_MOTION:     n_cfg.min_motion_ms     = i_cfg_wdata;
                mcaq_pkg::CFG_DEBOUNCE:       n_cfg.debounce_ms       = i_cfg_wdata;
                mcaq_pkg::CFG_CONFIRM_WINDOW: n_cfg.confirm_window_ms = i_cfg_wdata;
                mcaq_pkg::CFG_CONFIRM_COUNT:
                    n_cfg.confirm_count = i_cfg_wdata[mcaq_pkg::COUNT_W-1:0];
                mcaq_pkg::CFG_ALARM_DURATION: n_cfg.alarm_duration_ms = i_cfg_wdata;
                default: ; // index beyond the list is dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.startup_time_ms   <= mcaq_pkg::RST_STARTUP_TIME;
            r_cfg.grace_ms          <= mcaq_pkg::RST_GRACE;
            r_cfg.min_motion_ms     <= mcaq_pkg::RST_MIN_MOTION;
            r_cfg.debounce_ms       <= mcaq_pkg::RST_DEBOUNCE;
            r_cfg.confirm_window_ms <= mcaq_pkg::RST_CONFIRM_WINDOW;
            r_cfg.confirm_count     <= mcaq_pkg::RST_CONFIRM_COUNT;
            r_cfg.alarm_duration_ms <= mcaq_pkg::RST_ALARM_DURATION;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/mcaq_eval.sv @@
// ----------------------------------------------------------------------------
// mcaq_eval
// Single-sample update: high-run timing, event qualification, window tally,
// alarm trigger and expiry.
// ----------------------------------------------------------------------------
module mcaq_eval (
    input  mcaq_pkg::t_cfg                  i_cfg,
    input  mcaq_pkg::t_state                i_state,
    input  logic                            i_level,
    input  logic [mcaq_pkg::TIME_W-1:0]     i_now,
    output mcaq_pkg::t_state                o_state,
    output mcaq_pkg::t_result               o_result
);

    logic                           in_grace;
    logic                           window_over;
    logic [mcaq_pkg::TIME_W-1:0]    high_ref;
    logic                           qualify;
    logic [mcaq_pkg::COUNT_W-1:0]   tally_inc;
    logic                           started;
    logic                           stopped;
    mcaq_pkg::t_state               mid;

    // all differences wrap modulo 2^32
    assign in_grace    = (i_now - i_cfg.startup_time_ms) < i_cfg.grace_ms;
    assign window_over = (i_now - i_state.window_begin) > i_cfg.confirm_window_ms;
    assign high_ref    = i_state.high_run ? i_state.high_begin : i_now;
    assign qualify     = ((i_now - high_ref) >= i_cfg.min_motion_ms)
                         && !i_state.event_latched && !in_grace
                         && ((i_now - i_state.last_event_time) > i_cfg.debounce_ms);
    assign tally_inc   = (i_state.event_tally == mcaq_pkg::COUNT_MAX)
                         ? mcaq_pkg::COUNT_MAX
                         : i_state.event_tally + mcaq_pkg::COUNT_W'(1);

    always_comb begin
        mid     = i_state;
        started = 1'b0;
        if (i_level) begin
            mid.high_run   = 1'b1;
            mid.high_begin = high_ref;
            if (qualify) begin
                if ((i_state.event_tally == '0) || window_over) begin
                    mid.event_tally  = mcaq_pkg::COUNT_W'(1);
                    mid.window_begin = i_now;
                end else if ((tally_inc >= i_cfg.confirm_count)
                             && !i_state.alarm_active) begin
                    mid.alarm_active = 1'b1;
                    mid.alarm_begin  = i_now;
                    mid.event_tally  = '0;
                    started          = 1'b1;
                end else begin
                    mid.event_tally = tally_inc;
                end
                mid.event_latched   = 1'b1;
                mid.last_event_time = i_now;
            end
        end else begin
            mid.high_run      = 1'b0;
            mid.event_latched = 1'b0;
            if ((i_state.event_tally != '0) && window_over) begin
                mid.event_tally = '0;
            end
        end
    end

    // expiry looks at the alarm state after a possible trigger
    assign stopped = mid.alarm_active
                     && ((i_now - mid.alarm_begin) > i_cfg.alarm_duration_ms);

    always_comb begin
        o_state = mid;
        if (stopped) begin
            o_state.alarm_active = 1'b0;
        end
    end

    assign o_result.alarm_on      = o_state.alarm_active;
    assign o_result.alarm_started = started;
    assign o_result.alarm_expired = stopped;
    assign o_result.events_seen   = o_state.event_tally;

endmodule

@@ hw/rtl/motion_confirm_alarm_qualifier.sv @@
// ----------------------------------------------------------------------------
// motion_confirm_alarm_qualifier
// Qualifies timestamped motion sensor samples into confirmed alarm events.
// ----------------------------------------------------------------------------
// data path: the sample waits in the input register and moves into the result
//   register when that slot is free
// throughput: one sample per cycle while the result side is not stalled
// reset: synchronous active-low; clears pipeline valids and all qualifier
//   state, loads configuration defaults
// ----------------------------------------------------------------------------
module motion_confirm_alarm_qualifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [mcaq_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [mcaq_pkg::CFG_W-1:0]          i_cfg_wdata,
    // sample stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mcaq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // motion_level, now_ms[31:0]
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mcaq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // alarm_on, alarm_started,
                                                               // alarm_expired, events_seen[7:0]
);

    mcaq_pkg::t_cfg                 cfg;
    mcaq_pkg::t_state               r_state;
    mcaq_pkg::t_state               n_state;
    mcaq_pkg::t_result              n_result;
    mcaq_pkg::t_result              r_result;

    logic                           r_in_valid;
    logic                           r_in_level;
    logic [mcaq_pkg::TIME_W-1:0]    r_in_now;
    logic                           r_out_valid;
    logic                           advance;
    logic                           in_beat;

    mcaq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mcaq_eval u_eval (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_level  (r_in_level),
        .i_now    (r_in_now),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // held sample moves into the result register when that slot is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_level <= s_axis_tdata[0];
            r_in_now   <= s_axis_tdata[mcaq_pkg::TIME_W:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(mcaq_pkg::OUT_TDATA_W - $bits(r_result)){1'b0}}, r_result};

endmodule

@@ hw/rtl/mcaq_checker.sv @@
// ----------------------------------------------------------------------------
// mcaq_checker
// Port-level checks on the result stream of the alarm qualifier.
// ----------------------------------------------------------------------------
module mcaq_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [mcaq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // trigger and expiry never land on the same sample
    a_start_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[2])
        else $error("alarm started and stopped on one sample");

    // a trigger leaves the alarm on and the tally cleared
    a_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0] && (m_axis_tdata[10:3] == 8'd0))
        else $error("trigger without alarm on or with tally left");

    // expiry leaves the alarm off
    a_stop_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[0])
        else $error("alarm still on after expiry");

endmodule

bind motion_confirm_alarm_qualifier mcaq_checker u_mcaq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb - motion confirmation alarm qualifier testbench
// Drives timestamped sensor samples into the qualifier and predicts every
// result beat with a cycle-free model of the event, window and alarm logic.
// Covers the grace, debounce, window and alarm-stop edges, timestamp wrap,
// several register settings including all-zero and all-ones, and a long run
// that drives the event tally into saturation. Both stream sides stall at
// random, apart from one stretch with no stalls at all.
// ----------------------------------------------------------------------------
package mcaq_check_pkg;

    import mcaq_pkg::*;

    class alarm_outcome_board;

        // register copy
        logic [TIME_W-1:0]  cfg_start;
        logic [TIME_W-1:0]  cfg_grace;
        logic [TIME_W-1:0]  cfg_min_high;
        logic [TIME_W-1:0]  cfg_debounce;
        logic [TIME_W-1:0]  cfg_window;
        logic [COUNT_W-1:0] cfg_need;
        logic [TIME_W-1:0]  cfg_hold;

        // qualifier state copy
        bit                 siren_on;
        logic [TIME_W-1:0]  siren_t0;
        logic [TIME_W-1:0]  prev_evt_t;
        bit                 evt_done;
        logic [COUNT_W-1:0] tally;
        logic [TIME_W-1:0]  win_t0;
        logic [TIME_W-1:0]  rise_t;
        bit                 in_high;

        t_result     outcome_q[$];
        int unsigned fails;

        function new();
            cfg_start    = RST_STARTUP_TIME;
            cfg_grace    = RST_GRACE;
            cfg_min_high = RST_MIN_MOTION;
            cfg_debounce = RST_DEBOUNCE;
            cfg_window   = RST_CONFIRM_WINDOW;
            cfg_need     = RST_CONFIRM_COUNT;
            cfg_hold     = RST_ALARM_DURATION;
            siren_on     = 1'b0;
            siren_t0     = '0;
            prev_evt_t   = '0;
            evt_done     = 1'b0;
            tally        = '0;
            win_t0       = '0;
            rise_t       = '0;
            in_high      = 1'b0;
            fails        = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_STARTUP_TIME:   cfg_start    = data;
                CFG_GRACE:          cfg_grace    = data;
                CFG_MIN_MOTION:     cfg_min_high = data;
                CFG_DEBOUNCE:       cfg_debounce = data;
                CFG_CONFIRM_WINDOW: cfg_window   = data;
                CFG_CONFIRM_COUNT:  cfg_need     = data[COUNT_W-1:0];
                CFG_ALARM_DURATION: cfg_hold     = data;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return outcome_q.size();
        endfunction

        // works out the result beat of one accepted sample
        function void take_sample(bit level, logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] since_start;
            logic [TIME_W-1:0] since_win;
            logic [TIME_W-1:0] since_rise;
            logic [TIME_W-1:0] since_evt;
            logic [TIME_W-1:0] since_siren;
            bit                grace;
            bit                win_over;
            t_result           r;
            since_start = now - cfg_start;
            since_win   = now - win_t0;
            grace       = since_start < cfg_grace;
            win_over    = since_win > cfg_window;
            r           = '0;
            if (level) begin
                if (!in_high) begin
                    in_high = 1'b1;
                    rise_t  = now;
                end
                since_rise = now - rise_t;
                since_evt  = now - prev_evt_t;
                if (since_rise >= cfg_min_high && !evt_done && !grace &&
                    since_evt > cfg_debounce) begin
                    if (tally == '0 || win_over) begin
                        // first event opens a fresh window
                        tally  = 1;
                        win_t0 = now;
                    end else begin
                        if (tally != COUNT_MAX)
                            tally = tally + 1'b1;
                        if (tally >= cfg_need && !siren_on) begin
                            siren_on        = 1'b1;
                            siren_t0        = now;
                            r.alarm_started = 1'b1;
                            tally           = '0;
                        end
                    end
                    evt_done   = 1'b1;
                    prev_evt_t = now;
                end
            end else begin
                in_high  = 1'b0;
                evt_done = 1'b0;
                if (tally != '0 && win_over)
                    tally = '0;
            end
            since_siren = now - siren_t0;
            if (siren_on && since_siren > cfg_hold) begin
                siren_on        = 1'b0;
                r.alarm_expired = 1'b1;
            end
            r.alarm_on    = siren_on;
            r.events_seen = tally;
            outcome_q.push_back(r);
        endfunction

        function void match_outcome(t_result got);
            t_result want;
            if (outcome_q.size() == 0) begin
                fails++;
                $error("result beat with no sample waiting: %h", got);
                return;
            end
            want = outcome_q.pop_front();
            if (got.alarm_on !== want.alarm_on) begin
                fails++;
                $error("alarm_on: expected %0d, got %0d", want.alarm_on, got.alarm_on);
            end
            if (got.alarm_started !== want.alarm_started) begin
                fails++;
                $error("alarm_started: expected %0d, got %0d",
                       want.alarm_started, got.alarm_started);
            end
            if (got.alarm_expired !== want.alarm_expired) begin
                fails++;
                $error("alarm_expired: expected %0d, got %0d",
                       want.alarm_expired, got.alarm_expired);
            end
            if (got.events_seen !== want.events_seen) begin
                fails++;
                $error("events_seen: expected %0d, got %0d",
                       want.events_seen, got.events_seen);
            end
        endfunction

    endclass

endpackage

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mcaq_pkg::*;
    import mcaq_check_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;   // not a register
    localparam int unsigned LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 6;

    typedef struct {
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] grace;
        logic [TIME_W-1:0] min_high;
        logic [TIME_W-1:0] debounce;
        logic [TIME_W-1:0] window;
        logic [CFG_W-1:0]  need;
        logic [TIME_W-1:0] hold;
    } qual_settings_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr = '0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // motion_level, now_ms[31:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // alarm_on, alarm_started,
                                                 // alarm_expired, events_seen[7:0]

    alarm_outcome_board board;
    int unsigned        idle_pct = 30;
    int unsigned        cycles = 0;

    motion_confirm_alarm_qualifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("[motion_confirm_alarm_qualifier] ERROR");
            $finish;
        end
    end

    // result side: check each accepted beat, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.match_outcome(t_result'(m_axis_tdata[$bits(t_result)-1:0]));
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic send_sample(bit level, logic [TIME_W-1:0] now);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-TIME_W-1){1'b0}}, now, level};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        board.take_sample(level, now);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    task automatic load_settings(qual_settings_t s, bit poke_spare);
        write_reg(CFG_STARTUP_TIME, s.start);
        write_reg(CFG_GRACE, s.grace);
        write_reg(CFG_MIN_MOTION, s.min_high);
        write_reg(CFG_DEBOUNCE, s.debounce);
        write_reg(CFG_CONFIRM_WINDOW, s.window);
        write_reg(CFG_CONFIRM_COUNT, s.need);
        write_reg(CFG_ALARM_DURATION, s.hold);
        if (poke_spare)
            write_reg(CFG_SPARE, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every result is back and the pipe is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly plausible level runs with forward time, some noise and jumps
    task automatic run_phase(int n, int unsigned step_max, int unsigned flip_pct,
                             int unsigned noise_pct, logic [TIME_W-1:0] t0);
        bit                lvl;
        logic [TIME_W-1:0] t;
        int unsigned       roll;
        lvl = 1'b0;
        t   = t0;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < noise_pct / 3) begin
                lvl = 1'($urandom_range(1));
                t   = $urandom;
            end else if (roll < noise_pct) begin
                lvl = 1'($urandom_range(1));
                t   = t + TIME_W'($urandom_range(0, 4 * step_max));
            end else begin
                if ($urandom_range(99) < flip_pct)
                    lvl = !lvl;
                t = t + TIME_W'($urandom_range(0, step_max));
            end
            send_sample(lvl, t);
        end
    endtask

    initial begin
        qual_settings_t s;
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset defaults
        send_sample(1'b1, 32'd0);          // in grace
        send_sample(1'b1, 32'd29999);      // last grace tick
        send_sample(1'b1, 32'd30000);      // grace over, first event
        send_sample(1'b1, 32'd30500);      // same high run, latched
        send_sample(1'b0, 32'd30600);
        send_sample(1'b1, 32'd31000);
        send_sample(1'b1, 32'd31499);      // one short of minimum high time
        send_sample(1'b1, 32'd32000);      // debounce exactly, no event
        send_sample(1'b1, 32'd32001);      // second event, alarm on
        send_sample(1'b0, 32'd33000);
        send_sample(1'b1, 32'd62001);      // alarm duration exactly, still on
        send_sample(1'b1, 32'd62002);      // alarm stops
        send_sample(1'b0, 32'd62100);
        send_sample(1'b1, 32'd70000);
        send_sample(1'b1, 32'd70500);      // opens a window
        send_sample(1'b0, 32'd80500);      // window end exactly, tally kept
        send_sample(1'b0, 32'd80501);      // window expired, tally cleared
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'h0000_01F4);  // across the timestamp wrap, back in grace: no event
        send_sample(1'b0, 32'h0000_0200);
        send_sample(1'b1, 32'h0000_0300);
        send_sample(1'b1, 32'h0000_09C5);  // still in grace after the wrap, no event
        settle();

        // small timings, confirm count of zero, one and a few
        for (int k = 0; k < 3; k++) begin
            s.start    = $urandom;
            s.grace    = $urandom_range(0, 300);
            s.min_high = $urandom_range(0, 40);
            s.debounce = $urandom_range(0, 60);
            s.window   = $urandom_range(100, 600);
            s.need     = (k == 0) ? 0 : (k == 1) ? 1 : $urandom_range(2, 5);
            s.hold     = $urandom_range(50, 800);
            load_settings(s, k == 1);
            run_phase(110, 40, 30, 10,
                      (k == 0) ? 32'hFFFF_FF00 : s.start + $urandom_range(0, 50));
            settle();
        end

        // all timings zero
        s.start    = '0;
        s.grace    = '0;
        s.min_high = '0;
        s.debounce = '0;
        s.window   = '0;
        s.need     = '0;
        s.hold     = '0;
        load_settings(s, 1'b0);
        run_phase(60, 3, 40, 5, $urandom);
        settle();

        // all ones
        s.start    = '1;
        s.grace    = '1;
        s.min_high = '1;
        s.debounce = '1;
        s.window   = '1;
        s.need     = '1;
        s.hold     = '1;
        load_settings(s, 1'b0);
        run_phase(30, 1000, 30, 50, $urandom);
        settle();

        // alarm held for good, every high beat an event: tally saturates;
        // no stalls on either side through this stretch
        idle_pct   = 0;
        s.start    = $urandom;
        s.grace    = '0;
        s.min_high = '0;
        s.debounce = '0;
        s.window   = '1;
        s.need     = 32'hFFFF_FF02;        // upper bits dropped
        s.hold     = '1;
        load_settings(s, 1'b1);
        run_phase(560, 50, 100, 0, $urandom);
        idle_pct = 30;
        settle();

        if (board.fails == 0 && board.pending() == 0) begin
            $display("[motion_confirm_alarm_qualifier] OK");
        end else begin
            $display("[motion_confirm_alarm_qualifier] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/mcaq_pkg.sv
hw/rtl/mcaq_cfg_regs.sv
hw/rtl/mcaq_eval.sv
hw/rtl/motion_confirm_alarm_qualifier.sv
hw/rtl/mcaq_checker.sv
test/tb.sv
